// ===== hdl/tty_line_editor_defines.svh =====
// Assertion macros of the line editor, used by the ready ring.
`ifndef TTY_LINE_EDITOR_DEFINES_SVH
`define TTY_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tle_pkg.sv =====
// Shared constants, codes and control structs of the line editor.
package tle_pkg;

  localparam int LINE_DEPTH  = 128;
  localparam int READY_DEPTH = 256;
  localparam int READ_MAX    = 64;

  localparam int LN_AW = $clog2(LINE_DEPTH);
  localparam int LN_CW = $clog2(LINE_DEPTH + 1);
  localparam int RQ_AW = $clog2(READY_DEPTH);
  localparam int RQ_CW = $clog2(READY_DEPTH + 1);

  // Input codes
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_READ = 1'b1;
  localparam logic [1:0] KEY_PRINT = 2'd0;
  localparam logic [1:0] KEY_ENTER = 2'd1;
  localparam logic [1:0] KEY_BKSP  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_ECHO    = 3'd0;
  localparam logic [2:0] KIND_BYTE    = 3'd1;
  localparam logic [2:0] KIND_ZERO    = 3'd2;
  localparam logic [2:0] KIND_BLOCKED = 3'd3;
  localparam logic [2:0] KIND_DROPPED = 3'd4;

  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [6:0] REQ_MAX = 7'(READ_MAX);

  typedef struct packed {
    logic             wr;
    logic [7:0]       wdata;
    logic             dec;
    logic             clr;
    logic             rd;
    logic [LN_AW-1:0] raddr;
  } line_cmd_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } ring_cmd_t;

  typedef struct packed {
    logic [RQ_CW-1:0] fill;
    logic             full;
    logic             empty;
  } ring_stat_t;

endpackage

// ===== hdl/tle_in_if.sv =====
// Key / read request channel.
interface tle_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [1:0] key_kind;
  logic [7:0] key_char;
  logic [6:0] read_max;

  modport source (output valid, action, key_kind, key_char, read_max, input ready);
  modport sink (input valid, action, key_kind, key_char, read_max, output ready);
endinterface

// ===== hdl/tle_out_if.sv =====
// Result channel: echoes, read bytes and status answers.
interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic [6:0] run_bytes;
  logic       last;
  logic       line_done;
  logic       overflow;

  modport source (output valid, kind, data_byte, run_bytes, last, line_done, overflow,
                  input ready);
  modport sink (input valid, kind, data_byte, run_bytes, last, line_done, overflow,
                output ready);
endinterface

// ===== hdl/tle_line_buf.sv =====
// Edit line memory with its length counter.
module tle_line_buf (
  input  logic                     clk,
  input  logic                     rst,
  input  tle_pkg::line_cmd_t       cmd,
  output logic [tle_pkg::LN_CW-1:0] len,
  output logic [7:0]               rdata
);

  logic [7:0] mem [tle_pkg::LINE_DEPTH];

  // Append at the current length, registered read at the copy index
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[len[tle_pkg::LN_AW-1:0]] <= cmd.wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[cmd.raddr];
    end
  end

  // Length: grows on append, shrinks on backspace, clears on enter or reset
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      len <= '0;
    end else if (cmd.wr) begin
      len <= len + 1'b1;
    end else if (cmd.dec) begin
      len <= len - 1'b1;
    end
  end

endmodule

// ===== hdl/tle_ready_ring.sv =====
// Ready queue: ring memory with head pointer and fill count.
`include "tty_line_editor_defines.svh"

module tle_ready_ring (
  input  logic                clk,
  input  logic                rst,
  input  tle_pkg::ring_cmd_t  cmd,
  output tle_pkg::ring_stat_t stat,
  output logic [7:0]          rdata
);

  logic [7:0]                mem [tle_pkg::READY_DEPTH];
  logic [tle_pkg::RQ_AW-1:0] head;
  logic [tle_pkg::RQ_CW-1:0] fill;
  logic [tle_pkg::RQ_AW:0]   tail_sum;
  logic [tle_pkg::RQ_AW-1:0] tail;
  logic [tle_pkg::RQ_AW-1:0] head_next;

  // Write slot is head + fill, wrapped once; the next head wraps after the last slot
  always_comb begin
    tail_sum = (tle_pkg::RQ_AW + 1)'(head) + (tle_pkg::RQ_AW + 1)'(fill);
    if (tail_sum >= (tle_pkg::RQ_AW + 1)'(tle_pkg::READY_DEPTH)) begin
      tail = tle_pkg::RQ_AW'(tail_sum - (tle_pkg::RQ_AW + 1)'(tle_pkg::READY_DEPTH));
    end else begin
      tail = tail_sum[tle_pkg::RQ_AW-1:0];
    end
    if (head == tle_pkg::RQ_AW'(tle_pkg::READY_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = head + 1'b1;
    end
  end

  assign stat.fill  = fill;
  assign stat.full  = (fill == tle_pkg::RQ_CW'(tle_pkg::READY_DEPTH));
  assign stat.empty = (fill == '0);

  // Storage
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= cmd.wdata;
    end
    if (cmd.pop) begin
      rdata <= mem[head];
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.push) begin
      fill <= fill + 1'b1;
    end else if (cmd.pop) begin
      head <= head_next;
      fill <= fill - 1'b1;
    end
  end

  `TLE_ASSERT_NOW(a_fill_bound, 1'b1, fill <= tle_pkg::RQ_CW'(tle_pkg::READY_DEPTH), "ready fill above depth")
  `TLE_ASSERT_NOW(a_no_push_full, cmd.push, !stat.full && !cmd.pop, "push into full ring or with pop")
  `TLE_ASSERT_NEXT(a_pop_count, cmd.pop && !stat.empty, fill == $past(fill) - 1'b1, "pop did not drop fill")
  `TLE_ASSERT_NOW(a_no_pop_empty, cmd.pop, !stat.empty, "pop from empty ring")

endmodule

// ===== hdl/tty_line_editor.sv =====
// Top level: sequencer, output register and the two byte stores.
//
// Console line editor. Items arrive on in_ch (action, key_kind, key_char,
// read_max) and results leave on out_ch (kind, data_byte, run_bytes, last,
// line_done, overflow); a transfer is valid and ready high at a clock edge.
// One sequencer steps each item through the edit line memory and the ready
// ring, at most one access to each per cycle; in_ch.ready is high only between items.
// Results per item:
//   printable, backspace, other key: at most one result
//   enter: the line copy loop moves the line into the ready queue, then
//     one newline result
//   read: one result per delivered byte; a zero request or an empty
//     queue gets a single answer.
// Results pass through a single output register; the sequencer waits while
// that register holds a result the receiver has not taken, so a stall on
// out_ch holds the block without losing or repeating a result.
// Reset (synchronous, rst high) empties the edit line and the ready queue;
// no clearing pass is needed, the block is ready on the next cycle.
module tty_line_editor (
  input logic     clk,
  input logic     rst,
  tle_in_if.sink  in_ch,
  tle_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_RD_ADDR = 3'd2;
  localparam logic [2:0] S_RD_OUT  = 3'd3;
  localparam logic [2:0] S_EN_COPY = 3'd4;
  localparam logic [2:0] S_EN_NL   = 3'd5;

  logic [2:0] state, state_next;

  // Latched item
  logic       act;
  logic [1:0] kkind;
  logic [7:0] kchar;
  logic [6:0] req;

  // Loop registers
  logic [tle_pkg::LN_CW-1:0] idx, idx_next;
  logic                      pend, pend_next;
  logic                      lost, lost_next;
  logic [6:0]                rd_cnt, rd_cnt_next;
  logic [6:0]                rd_i, rd_i_next;

  // Output register
  logic       out_valid;
  logic       out_free;
  logic       emit;
  logic [2:0] e_kind;
  logic [7:0] e_data;
  logic [6:0] e_count;
  logic       e_last, e_done, e_ovf;

  tle_pkg::line_cmd_t        lcmd;
  logic [tle_pkg::LN_CW-1:0] len;
  logic [7:0]                line_rdata;
  tle_pkg::ring_cmd_t        rcmd;
  tle_pkg::ring_stat_t       rstat;
  logic [7:0]                ring_rdata;

  tle_line_buf u_line (
    .clk   (clk),
    .rst   (rst),
    .cmd   (lcmd),
    .len   (len),
    .rdata (line_rdata)
  );

  tle_ready_ring u_ring (
    .clk   (clk),
    .rst   (rst),
    .cmd   (rcmd),
    .stat  (rstat),
    .rdata (ring_rdata)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign out_free    = !out_valid || out_ch.ready;

  // Capture the item, saturating the request size
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      act   <= in_ch.action;
      kkind <= in_ch.key_kind;
      kchar <= in_ch.key_char;
      req   <= (in_ch.read_max > tle_pkg::REQ_MAX) ? tle_pkg::REQ_MAX : in_ch.read_max;
    end
  end

  // Sequencer
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    pend_next   = pend;
    lost_next   = lost;
    rd_cnt_next = rd_cnt;
    rd_i_next   = rd_i;
    lcmd        = '0;
    rcmd        = '0;
    emit        = 1'b0;
    e_kind      = tle_pkg::KIND_ECHO;
    e_data      = '0;
    e_count     = '0;
    e_last      = 1'b1;
    e_done      = 1'b0;
    e_ovf       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (out_free) begin
          state_next = S_IDLE;
          if (act == tle_pkg::ACT_READ) begin
            if (req == '0) begin
              emit   = 1'b1;
              e_kind = tle_pkg::KIND_ZERO;
            end else if (rstat.empty) begin
              emit   = 1'b1;
              e_kind = tle_pkg::KIND_BLOCKED;
            end else begin
              rd_cnt_next = (32'(rstat.fill) < 32'(req)) ? 7'(rstat.fill) : req;
              rd_i_next   = '0;
              state_next  = S_RD_ADDR;
            end
          end else begin
            case (kkind)
              tle_pkg::KEY_PRINT: begin
                emit = 1'b1;
                if (len == tle_pkg::LN_CW'(tle_pkg::LINE_DEPTH)) begin
                  e_kind = tle_pkg::KIND_DROPPED;
                  e_ovf  = 1'b1;
                end else begin
                  lcmd.wr    = 1'b1;
                  lcmd.wdata = kchar;
                  e_data     = kchar;
                end
              end
              tle_pkg::KEY_ENTER: begin
                idx_next   = '0;
                pend_next  = 1'b0;
                lost_next  = 1'b0;
                state_next = S_EN_COPY;
              end
              tle_pkg::KEY_BKSP: begin
                if (len != '0) begin
                  lcmd.dec = 1'b1;
                  emit     = 1'b1;
                  e_data   = tle_pkg::CH_BS;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_RD_ADDR: begin
        rcmd.pop   = 1'b1;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = tle_pkg::KIND_BYTE;
          e_data    = ring_rdata;
          e_count   = rd_cnt;
          e_last    = (rd_i + 1'b1 == rd_cnt);
          rd_i_next = rd_i + 1'b1;
          state_next = e_last ? S_IDLE : S_RD_ADDR;
        end
      end
      S_EN_COPY: begin
        // Read the next line byte while pushing (or dropping, when the ring is full) the one read last cycle
        lcmd.rd    = (idx < len);
        lcmd.raddr = idx[tle_pkg::LN_AW-1:0];
        if (lcmd.rd) begin
          idx_next = idx + 1'b1;
        end
        pend_next = lcmd.rd;
        if (pend) begin
          if (rstat.full) begin
            lost_next = 1'b1;
          end else begin
            rcmd.push  = 1'b1;
            rcmd.wdata = line_rdata;
          end
        end
        if (!lcmd.rd && !pend) begin
          state_next = S_EN_NL;
        end
      end
      S_EN_NL: begin
        if (out_free) begin
          if (!rstat.full) begin
            rcmd.push  = 1'b1;
            rcmd.wdata = tle_pkg::CH_NL;
          end
          lcmd.clr   = 1'b1;
          emit       = 1'b1;
          e_data     = tle_pkg::CH_NL;
          e_done     = 1'b1;
          e_ovf      = lost || rstat.full;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    idx    <= idx_next;
    pend   <= pend_next;
    lost   <= lost_next;
    rd_cnt <= rd_cnt_next;
    rd_i   <= rd_i_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      out_ch.kind      <= e_kind;
      out_ch.data_byte <= e_data;
      out_ch.run_bytes <= e_count;
      out_ch.last      <= e_last;
      out_ch.line_done <= e_done;
      out_ch.overflow  <= e_ovf;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ===== test/tty_line_editor_test.sv =====
// Self-checking testbench for the tty_line_editor console line editor.
`timescale 1ns / 1ps

module tty_line_editor_test;

  localparam logic [1:0] KEY_OTHER = 2'd3;
  localparam int LIMIT = 1_000_000;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_WAIT = 200;
  localparam int SAT_ITEMS = 2 * tle_pkg::LINE_DEPTH + 6;
  localparam int RANDOM_ITEMS = 30;
  localparam int CALM_ITEMS = 12;

  typedef struct packed {
    logic       action;
    logic [1:0] key_kind;
    logic [7:0] key_char;
    logic [6:0] read_max;
  } key_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [6:0] run_bytes;
    logic       last;
    logic       line_done;
    logic       overflow;
  } console_result_t;

  typedef struct packed {
    key_item_t       item;
    logic            typed;
    console_result_t res;
  } directed_row_t;

  localparam console_result_t NO_RES = '0;
  localparam int N_DIRECTED = 20;
  localparam int TOTAL_ITEMS = N_DIRECTED + SAT_ITEMS + RANDOM_ITEMS;

  // Directed sequence; typed rows carry their obvious answer, the rest go to the predictor
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{'{tle_pkg::ACT_READ, tle_pkg::KEY_PRINT, 8'h00, 7'd5}, 1'b1,
      '{tle_pkg::KIND_BLOCKED, 8'h00, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_READ, tle_pkg::KEY_PRINT, 8'h00, 7'd0}, 1'b1,
      '{tle_pkg::KIND_ZERO, 8'h00, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_KEY, tle_pkg::KEY_BKSP, 8'hFF, 7'd127}, 1'b0, NO_RES},
    '{'{tle_pkg::ACT_KEY, KEY_OTHER, 8'hFF, 7'd0}, 1'b0, NO_RES},
    '{'{tle_pkg::ACT_KEY, tle_pkg::KEY_PRINT, 8'h00, 7'd0}, 1'b1,
      '{tle_pkg::KIND_ECHO, 8'h00, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_KEY, tle_pkg::KEY_PRINT, 8'hFF, 7'd127}, 1'b1,
      '{tle_pkg::KIND_ECHO, 8'hFF, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_KEY, tle_pkg::KEY_PRINT, 8'h55, 7'd64}, 1'b1,
      '{tle_pkg::KIND_ECHO, 8'h55, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_KEY, tle_pkg::KEY_PRINT, 8'hAA, 7'd1}, 1'b1,
      '{tle_pkg::KIND_ECHO, 8'hAA, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_KEY, tle_pkg::KEY_BKSP, 8'h00, 7'd0}, 1'b1,
      '{tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_KEY, tle_pkg::KEY_ENTER, 8'hFF, 7'd0}, 1'b1,
      '{tle_pkg::KIND_ECHO, tle_pkg::CH_NL, 7'd0, 1'b1, 1'b1, 1'b0}},
    '{'{tle_pkg::ACT_KEY, tle_pkg::KEY_ENTER, 8'h00, 7'd127}, 1'b1,
      '{tle_pkg::KIND_ECHO, tle_pkg::CH_NL, 7'd0, 1'b1, 1'b1, 1'b0}},
    '{'{tle_pkg::ACT_READ, KEY_OTHER, 8'hFF, 7'd1}, 1'b1,
      '{tle_pkg::KIND_BYTE, 8'h00, 7'd1, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_READ, tle_pkg::KEY_ENTER, 8'h00, 7'd127}, 1'b0, NO_RES},
    '{'{tle_pkg::ACT_READ, tle_pkg::KEY_BKSP, 8'h00, 7'd64}, 1'b1,
      '{tle_pkg::KIND_BLOCKED, 8'h00, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_READ, tle_pkg::KEY_ENTER, 8'hFF, 7'd0}, 1'b1,
      '{tle_pkg::KIND_ZERO, 8'h00, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_KEY, tle_pkg::KEY_PRINT, 8'h80, 7'd0}, 1'b1,
      '{tle_pkg::KIND_ECHO, 8'h80, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_KEY, tle_pkg::KEY_PRINT, 8'h01, 7'd0}, 1'b1,
      '{tle_pkg::KIND_ECHO, 8'h01, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{'{tle_pkg::ACT_KEY, tle_pkg::KEY_ENTER, 8'h00, 7'd0}, 1'b1,
      '{tle_pkg::KIND_ECHO, tle_pkg::CH_NL, 7'd0, 1'b1, 1'b1, 1'b0}},
    '{'{tle_pkg::ACT_READ, tle_pkg::KEY_PRINT, 8'h00, 7'd2}, 1'b0, NO_RES},
    '{'{tle_pkg::ACT_READ, tle_pkg::KEY_PRINT, 8'h00, 7'd64}, 1'b0, NO_RES}
  };

  logic clk;
  logic rst;

  tle_in_if  in_ch ();
  tle_out_if out_ch ();

  tty_line_editor i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow state of the editor
  logic [7:0]      line_buf [tle_pkg::LINE_DEPTH];
  int              line_len;
  logic [7:0]      ready_bytes [$];
  console_result_t awaited_results [$];

  int mismatches = 0;
  int cycle_count = 0;
  int sent_items;
  int send_idle_pct = 10;
  int recv_idle_pct = 10;
  bit calm;
  bit hold_results;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog and idle-rate shuffling; rate 0 gives stretches with no idling
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tty_line_editor regression: fail");
      $finish;
    end
    if (cycle_count % 64 == 0) begin
      case ($urandom_range(0, 2))
        0: send_idle_pct <= 0;
        1: send_idle_pct <= 10;
        default: send_idle_pct <= 30;
      endcase
      case ($urandom_range(0, 2))
        0: recv_idle_pct <= 0;
        1: recv_idle_pct <= 10;
        default: recv_idle_pct <= 30;
      endcase
    end
  end

  function automatic key_item_t key_item(logic act, logic [1:0] kk, logic [7:0] ch,
                                         logic [6:0] rmax);
    key_item_t it;
    it.action   = act;
    it.key_kind = kk;
    it.key_char = ch;
    it.read_max = rmax;
    return it;
  endfunction

  function automatic void note_result(logic [2:0] kind, logic [7:0] data, logic [6:0] count,
                                      logic last, logic done, logic ovf);
    console_result_t r;
    r.kind      = kind;
    r.data_byte = data;
    r.run_bytes = count;
    r.last      = last;
    r.line_done = done;
    r.overflow  = ovf;
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  // Editor behavior for one accepted item: updates shadow state, queues the results
  function automatic void edit_console(key_item_t it);
    logic [6:0] req;
    int         n;
    logic       lost;
    logic [7:0] b;
    if (it.action == tle_pkg::ACT_READ) begin
      req = (it.read_max > tle_pkg::REQ_MAX) ? tle_pkg::REQ_MAX : it.read_max;
      if (req == 0) begin
        note_result(tle_pkg::KIND_ZERO, 8'h00, 7'd0, 1'b1, 1'b0, 1'b0);
      end else if (ready_bytes.size() == 0) begin
        note_result(tle_pkg::KIND_BLOCKED, 8'h00, 7'd0, 1'b1, 1'b0, 1'b0);
      end else begin
        n = (req < ready_bytes.size()) ? int'(req) : ready_bytes.size();
        for (int i = 0; i < n; i++) begin
          b = ready_bytes[0];
          ready_bytes.delete(0);
          note_result(tle_pkg::KIND_BYTE, b, 7'(n), i == n - 1, 1'b0, 1'b0);
        end
      end
    end else begin
      case (it.key_kind)
        tle_pkg::KEY_PRINT: begin
          if (line_len >= tle_pkg::LINE_DEPTH) begin
            note_result(tle_pkg::KIND_DROPPED, 8'h00, 7'd0, 1'b1, 1'b0, 1'b1);
          end else begin
            line_buf[line_len] = it.key_char;
            line_len++;
            note_result(tle_pkg::KIND_ECHO, it.key_char, 7'd0, 1'b1, 1'b0, 1'b0);
          end
        end
        tle_pkg::KEY_ENTER: begin
          lost = 1'b0;
          // line plus newline into the ready queue; whatever does not fit is lost
          for (int i = 0; i <= line_len; i++) begin
            if (ready_bytes.size() < tle_pkg::READY_DEPTH)
              ready_bytes.insert(ready_bytes.size(),
                                 i == line_len ? tle_pkg::CH_NL : line_buf[i]);
            else
              lost = 1'b1;
          end
          line_len = 0;
          note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_NL, 7'd0, 1'b1, 1'b1, lost);
        end
        tle_pkg::KEY_BKSP: begin
          if (line_len > 0) begin
            line_len--;
            note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 7'd0, 1'b1, 1'b0, 1'b0);
          end
        end
        default: ;
      endcase
    end
  endfunction

  // Offer one item, wait for its transfer, then maybe idle for a burst
  task automatic offer_item(input key_item_t it, input bit typed, input console_result_t tres);
    int base;
    int gap;
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.action   = it.action;
    in_ch.key_kind = it.key_kind;
    in_ch.key_char = it.key_char;
    in_ch.read_max = it.read_max;
    do @(posedge clk); while (!in_ch.ready);
    base = awaited_results.size();
    edit_console(it);
    if (typed) begin
      while (awaited_results.size() > base)
        awaited_results.delete(awaited_results.size() - 1);
      awaited_results.insert(awaited_results.size(), tres);
    end
    sent_items++;
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send(input key_item_t it);
    offer_item(it, 1'b0, NO_RES);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  function automatic void take_result();
    console_result_t e;
    if (awaited_results.size() == 0) begin
      $error("result with nothing expected: kind %0d data_byte %0d", out_ch.kind,
             out_ch.data_byte);
      mismatches++;
      return;
    end
    e = awaited_results[0];
    awaited_results.delete(0);
    check_field("kind", e.kind, out_ch.kind);
    check_field("data_byte", e.data_byte, out_ch.data_byte);
    check_field("run_bytes", e.run_bytes, out_ch.run_bytes);
    check_field("last", e.last, out_ch.last);
    check_field("line_done", e.line_done, out_ch.line_done);
    check_field("overflow", e.overflow, out_ch.overflow);
  endfunction

  // Result side: sample at the rising edge, move ready at the falling edge
  initial begin : result_sink
    int  burst_left;
    int  long_left;
    bit  long_done;
    burst_left   = 0;
    long_left    = 0;
    long_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) take_result();
      @(negedge clk);
      if (hold_results && !long_done) begin
        long_left = LONG_HOLD;
        long_done = 1'b1;
      end
      if (long_left > 0) begin
        out_ch.ready = 1'b0;
        long_left--;
      end else if (burst_left > 0) begin
        out_ch.ready = 1'b0;
        burst_left--;
      end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
        out_ch.ready = 1'b0;
        burst_left   = $urandom_range(1, 3) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int pick;
    int word_len;
    int roll;
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.action   = tle_pkg::ACT_KEY;
    in_ch.key_kind = tle_pkg::KEY_PRINT;
    in_ch.key_char = 8'h00;
    in_ch.read_max = 7'd0;
    line_len       = 0;
    sent_items     = 0;
    calm           = 1'b0;
    hold_results   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (int i = 0; i < N_DIRECTED; i++)
      offer_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].res);
    wait_drained();

    // Saturation: overfill the edit line, then the ready queue, while results are held off
    hold_results = 1'b1;
    repeat (tle_pkg::LINE_DEPTH + 1)
      send(key_item(tle_pkg::ACT_KEY, tle_pkg::KEY_PRINT, 8'($urandom), 7'($urandom)));
    send(key_item(tle_pkg::ACT_KEY, tle_pkg::KEY_ENTER, 8'($urandom), 7'($urandom)));
    repeat (tle_pkg::LINE_DEPTH - 1)
      send(key_item(tle_pkg::ACT_KEY, tle_pkg::KEY_PRINT, 8'($urandom), 7'($urandom)));
    send(key_item(tle_pkg::ACT_KEY, tle_pkg::KEY_ENTER, 8'($urandom), 7'($urandom)));
    send(key_item(tle_pkg::ACT_KEY, tle_pkg::KEY_ENTER, 8'($urandom), 7'($urandom)));
    repeat (2)
      send(key_item(tle_pkg::ACT_READ, 2'($urandom), 8'($urandom),
                    7'($urandom_range(64, 127))));
    send(key_item(tle_pkg::ACT_READ, 2'($urandom), 8'($urandom), 7'd64));
    wait_drained();

    // Random: mostly typed words and reads, some noise; no idling near the end
    while (sent_items < TOTAL_ITEMS) begin
      if (sent_items >= TOTAL_ITEMS - CALM_ITEMS)
        calm = 1'b1;
      roll = $urandom_range(0, 9);
      if (roll <= 5) begin
        word_len = $urandom_range(1, 8);
        for (int k = 0; k < word_len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 10)
            send(key_item(tle_pkg::ACT_KEY, tle_pkg::KEY_BKSP, 8'($urandom), 7'($urandom)));
          else if (pick < 15)
            send(key_item(tle_pkg::ACT_KEY, KEY_OTHER, 8'($urandom), 7'($urandom)));
          else
            send(key_item(tle_pkg::ACT_KEY, tle_pkg::KEY_PRINT, 8'($urandom), 7'($urandom)));
        end
        if ($urandom_range(0, 9) != 0)
          send(key_item(tle_pkg::ACT_KEY, tle_pkg::KEY_ENTER, 8'($urandom), 7'($urandom)));
      end else if (roll <= 7) begin
        pick = $urandom_range(0, 9);
        send(key_item(tle_pkg::ACT_READ, 2'($urandom), 8'($urandom),
                      pick == 0 ? 7'd0 : pick == 1 ? 7'($urandom_range(65, 127)) :
                      7'($urandom_range(1, 24))));
      end else begin
        send(key_item(1'($urandom), 2'($urandom), 8'($urandom), 7'($urandom)));
      end
    end

    // Drain, then allow the longest item time to show any stray result
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("tty_line_editor regression: pass");
    else
      $display("tty_line_editor regression: fail");
    $finish;
  end

endmodule
